[rtl/core/ssjac_pkg.sv]
// shared constants, codes and types for the sorted-set jaccard block
package ssjac_pkg;

  localparam int MAX_HASHES = 4096;
  localparam int HASH_BITS  = 32;
  localparam int ADDR_W     = $clog2(MAX_HASHES);
  localparam int SIZE_W     = ADDR_W + 1;
  localparam int UNION_W    = SIZE_W + 1;
  localparam int FRAC_W     = 16;
  localparam int SIM_W      = FRAC_W + 1;
  localparam int THR_W      = FRAC_W + 1;
  localparam int NUM_W      = SIZE_W + FRAC_W;
  localparam int PROD_W     = THR_W + UNION_W;
  localparam int DCNT_W     = $clog2(NUM_W);

  typedef enum logic [1:0] {
    FUNC_APPEND_REF = 2'd0,
    FUNC_APPEND_QRY = 2'd1,
    FUNC_COMPARE    = 2'd2,
    FUNC_CLEAR      = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MERGE,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] common;
  } merge_stat_t;

endpackage

[rtl/core/ssjac_list.sv]
// hash list memory, one write port and one registered read port
module ssjac_list
  import ssjac_pkg::*;
(
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  logic [HASH_BITS-1:0] wr_data,
  input  logic [ADDR_W-1:0]    rd_addr,
  output logic [HASH_BITS-1:0] rd_data
);

  logic [HASH_BITS-1:0] mem [MAX_HASHES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/core/ssjac_merge.sv]
// merge walk over both lists, one compare step per cycle
module ssjac_merge
  import ssjac_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [SIZE_W-1:0]    ref_size,
  input  logic [SIZE_W-1:0]    qry_size,
  input  logic [HASH_BITS-1:0] ref_data,
  input  logic [HASH_BITS-1:0] qry_data,
  output logic [ADDR_W-1:0]    ref_addr,
  output logic [ADDR_W-1:0]    qry_addr,
  output merge_stat_t          stat
);

  logic              run;
  logic [SIZE_W-1:0] ref_idx;
  logic [SIZE_W-1:0] qry_idx;
  logic [SIZE_W-1:0] common;
  logic [SIZE_W-1:0] ref_idx_next;
  logic [SIZE_W-1:0] qry_idx_next;
  logic              live;
  logic              is_less;
  logic              is_equal;

  assign live     = (ref_idx < ref_size) && (qry_idx < qry_size);
  assign is_less  = ref_data < qry_data;
  assign is_equal = ref_data == qry_data;

  always_comb begin
    ref_idx_next = ref_idx;
    qry_idx_next = qry_idx;
    if (is_equal) begin
      ref_idx_next = ref_idx + SIZE_W'(1);
      qry_idx_next = qry_idx + SIZE_W'(1);
    end else if (is_less) begin
      ref_idx_next = ref_idx + SIZE_W'(1);
    end else begin
      qry_idx_next = qry_idx + SIZE_W'(1);
    end
  end

  // addresses lead the index registers so read data lines up next cycle
  assign ref_addr = run ? ref_idx_next[ADDR_W-1:0] : '0;
  assign qry_addr = run ? qry_idx_next[ADDR_W-1:0] : '0;

  assign stat.done   = run && !live;
  assign stat.common = common;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
    end else if (start) begin
      run <= 1'b1;
    end else if (run && !live) begin
      run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ref_idx <= '0;
      qry_idx <= '0;
      common  <= '0;
    end else if (run && live) begin
      ref_idx <= ref_idx_next;
      qry_idx <= qry_idx_next;
      if (is_equal) begin
        common <= common + SIZE_W'(1);
      end
    end
  end

endmodule

[rtl/core/ssjac_div.sv]
// restoring divider, one quotient bit per cycle
module ssjac_div
  import ssjac_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [SIZE_W-1:0]  dividend_hi,
  input  logic [UNION_W-1:0] divisor,
  output logic               done,
  output logic [SIM_W-1:0]   quotient
);

  logic               run;
  logic [DCNT_W-1:0]  count;
  logic [NUM_W-1:0]   work;
  logic [UNION_W-1:0] rem;
  logic [UNION_W-1:0] dvs;
  logic [UNION_W:0]   rem_sh;
  logic               q_bit;
  logic [UNION_W:0]   diff;

  assign rem_sh   = {rem, work[NUM_W-1]};
  assign q_bit    = rem_sh >= {1'b0, dvs};
  assign diff     = rem_sh - {1'b0, dvs};
  assign done     = run && (count == DCNT_W'(NUM_W - 1));
  // last quotient bit is decided in the done cycle, so take it straight from the compare
  assign quotient = {work[SIM_W-2:0], q_bit};

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      count <= '0;
    end else if (start) begin
      run   <= 1'b1;
      count <= '0;
    end else if (run) begin
      count <= count + DCNT_W'(1);
      if (done) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= {dividend_hi, {FRAC_W{1'b0}}};
      rem  <= '0;
      dvs  <= divisor;
    end else if (run) begin
      work <= {work[NUM_W-2:0], q_bit};
      rem  <= q_bit ? diff[UNION_W-1:0] : rem_sh[UNION_W-1:0];
    end
  end

endmodule

[rtl/core/sorted_set_jaccard_similarity_top.sv]
// top level: list loading, merge compare, jaccard ratio and neighbor test
//
// channel  | handshake          | payload
// ---------+--------------------+-----------------------------------------------
// command  | start, busy        | func, hash_value
// result   | done (1-cycle)     | common_count, union_count, similarity_q16,
//          |                    | is_neighbor, list_overflow
// config   | cfg_wr_en          | cfg_wr_data (jaccard_min_q16)
//
// appends and clears leave busy low, so while no compare is running a
// transaction can be issued every cycle. a compare walks both lists through the
// merge unit, one step per cycle, then the restoring divider runs; done pulses
// the cycle after the divider finishes.
// reset is synchronous; list contents are not cleared, only the sizes, the overflow flag and the threshold.
// the receiver cannot stall: done is high for a single cycle, and the payload is held until the next compare ends.
module sorted_set_jaccard_similarity_top
  import ssjac_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           func,
  input  logic [31:0]          hash_value,
  input  logic                 cfg_wr_en,
  input  logic [THR_W-1:0]     cfg_wr_data,
  output logic                 done,
  output logic [SIZE_W-1:0]    common_count,
  output logic [UNION_W-1:0]   union_count,
  output logic [SIM_W-1:0]     similarity_q16,
  output logic                 is_neighbor,
  output logic                 list_overflow
);

  state_t state;
  state_t state_next;

  logic [THR_W-1:0]     jaccard_min_q16;
  logic [SIZE_W-1:0]    ref_size;
  logic [SIZE_W-1:0]    qry_size;
  logic                 overflow_seen;
  logic [UNION_W-1:0]   union_latched;
  logic [PROD_W-1:0]    thr_prod;

  logic                 accept;
  func_t                func_code;
  logic                 ref_full;
  logic                 qry_full;
  logic                 ref_wr;
  logic                 qry_wr;
  logic                 merge_start;
  logic                 div_start;
  logic [UNION_W-1:0]   union_calc;

  logic [ADDR_W-1:0]    ref_addr;
  logic [ADDR_W-1:0]    qry_addr;
  logic [HASH_BITS-1:0] ref_data;
  logic [HASH_BITS-1:0] qry_data;
  merge_stat_t          mstat;
  logic                 div_done;
  logic [SIM_W-1:0]     quotient;
  logic [PROD_W-1:0]    scaled_common;

  assign busy      = state != ST_IDLE;
  assign accept    = start && !busy;
  assign func_code = func_t'(func);
  assign ref_full  = ref_size >= SIZE_W'(MAX_HASHES);
  assign qry_full  = qry_size >= SIZE_W'(MAX_HASHES);
  assign ref_wr    = accept && (func_code == FUNC_APPEND_REF) && !ref_full;
  assign qry_wr    = accept && (func_code == FUNC_APPEND_QRY) && !qry_full;

  // union never goes negative: the merge count is bounded by either size
  assign union_calc = UNION_W'(ref_size) + UNION_W'(qry_size) - UNION_W'(mstat.common);

  // common * 65536 lined up against the threshold product
  assign scaled_common = PROD_W'({union_latched == '0 ? mstat.common : mstat.common,
                                  {FRAC_W{1'b0}}});

  ssjac_list u_ref_list (
    .clk     (clk),
    .wr_en   (ref_wr),
    .wr_addr (ref_size[ADDR_W-1:0]),
    .wr_data (hash_value[HASH_BITS-1:0]),
    .rd_addr (ref_addr),
    .rd_data (ref_data)
  );

  ssjac_list u_qry_list (
    .clk     (clk),
    .wr_en   (qry_wr),
    .wr_addr (qry_size[ADDR_W-1:0]),
    .wr_data (hash_value[HASH_BITS-1:0]),
    .rd_addr (qry_addr),
    .rd_data (qry_data)
  );

  ssjac_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .start    (merge_start),
    .ref_size (ref_size),
    .qry_size (qry_size),
    .ref_data (ref_data),
    .qry_data (qry_data),
    .ref_addr (ref_addr),
    .qry_addr (qry_addr),
    .stat     (mstat)
  );

  ssjac_div u_div (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .dividend_hi (mstat.common),
    .divisor     (union_calc),
    .done        (div_done),
    .quotient    (quotient)
  );

  // sequencer: next state and unit kicks
  always_comb begin
    state_next  = state;
    merge_start = 1'b0;
    div_start   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept && (func_code == FUNC_COMPARE)) begin
          merge_start = 1'b1;
          state_next  = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (mstat.done) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // threshold register, written any time the port strobes
  always_ff @(posedge clk) begin
    if (rst) begin
      jaccard_min_q16 <= '0;
    end else if (cfg_wr_en) begin
      jaccard_min_q16 <= cfg_wr_data;
    end
  end

  // list sizes and sticky overflow
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_size      <= '0;
      qry_size      <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (accept) begin
        unique case (func_code)
          FUNC_APPEND_REF: begin
            if (ref_full) begin
              overflow_seen <= 1'b1;
            end else begin
              ref_size <= ref_size + SIZE_W'(1);
            end
          end
          FUNC_APPEND_QRY: begin
            if (qry_full) begin
              overflow_seen <= 1'b1;
            end else begin
              qry_size <= qry_size + SIZE_W'(1);
            end
          end
          FUNC_CLEAR: begin
            ref_size      <= '0;
            qry_size      <= '0;
            overflow_seen <= 1'b0;
          end
          FUNC_COMPARE: begin
          end
          default: begin
          end
        endcase
      end
      // compare empties the query list once the result is out
      if ((state == ST_DIV) && div_done) begin
        qry_size <= '0;
      end
    end
  end

  // union and threshold product latched as the merge ends
  always_ff @(posedge clk) begin
    if (div_start) begin
      union_latched <= union_calc;
      thr_prod      <= PROD_W'(jaccard_min_q16) * PROD_W'(union_calc);
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_DIV) && div_done;
    end
  end

  // result payload, held until the next compare
  always_ff @(posedge clk) begin
    if ((state == ST_DIV) && div_done) begin
      common_count   <= mstat.common;
      union_count    <= union_latched;
      similarity_q16 <= (union_latched == '0) ? '0 : quotient;
      is_neighbor    <= scaled_common >= thr_prod;
      list_overflow  <= overflow_seen;
    end
  end

endmodule
